// ----- rtl/line_prefix_capture_relay_core_defines.svh -----
// Assertion macros shared by the relay checker.
`ifndef LINE_PREFIX_CAPTURE_RELAY_CORE_DEFINES_SVH
`define LINE_PREFIX_CAPTURE_RELAY_CORE_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define LPCR_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("relay check failed: same-cycle rule");

// Next-cycle implication, checked outside reset.
`define LPCR_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("relay check failed: next-cycle rule");

`endif

// ----- rtl/lpcr_pkg.sv -----
// Constants shared by the line prefix capture relay and its checker.
package lpcr_pkg;

  // Characters that the prefix matchers look for.
  localparam logic [7:0] CH_QUEST = 8'h3F;
  localparam logic [7:0] CH_R     = 8'h52;
  localparam logic [7:0] CH_L     = 8'h4C;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_NL    = 8'h0A;
  localparam logic [7:0] CH_BANG  = 8'h21;
  localparam logic [7:0] CH_N     = 8'h4E;
  localparam logic [7:0] CH_P     = 8'h50;

  // Match position codes within the current line.
  typedef logic [2:0] pos_t;
  localparam pos_t POS_START   = 3'd0;
  localparam pos_t POS_ONE     = 3'd1;
  localparam pos_t POS_TWO     = 3'd2;
  localparam pos_t POS_THREE   = 3'd3;
  localparam pos_t POS_FOUR    = 3'd4;
  localparam pos_t POS_CAPTURE = 3'd5;
  localparam pos_t POS_REJECT  = 3'd6;

endpackage

// ----- rtl/line_prefix_capture_relay_core.sv -----
// Half-duplex byte relay that flags "?RL " / "?RLR " lines for capture and turns on newlines.
// The relay takes one word per cycle while result_ready is high and hands back one result
// word for each in the cycle after acceptance, from its result register; the input side
// keeps taking as that register drains, at one word per clock. Downstream (to_upstream = 0),
// a line that starts with "?RL " or "?RLR " has the rest of its bytes flagged with capture,
// the closing newline also raising flush; any newline turns the relay toward upstream.
// Upstream, a line that is exactly "!N " or "!P " plus newline turns it back; a line cut
// short by a newline is rejected and the following line is skipped.
module line_prefix_capture_relay_core (
  input  logic       clk,
  input  logic       rst,
  input  logic       data_valid,
  output logic       data_ready,
  input  logic [7:0] data_byte,
  output logic       result_valid,
  input  logic       result_ready,
  output logic [7:0] out_byte,
  output logic       to_upstream,
  output logic       capture,
  output logic       flush,
  output logic       turned
);

  logic             listen_up;
  logic             listen_up_next;
  lpcr_pkg::pos_t   pos;
  lpcr_pkg::pos_t   pos_next;
  logic             cap_next;
  logic             flush_next;
  logic             turn_next;
  logic             is_nl;
  logic             accept;

  // The result register frees up when it is empty or being drained.
  assign data_ready = !result_valid || result_ready;
  assign accept     = data_valid && data_ready;
  assign is_nl      = (data_byte == lpcr_pkg::CH_NL);

  // Prefix matching for the incoming word in the current direction.
  always_comb begin
    pos_next       = pos;
    listen_up_next = listen_up;
    cap_next       = 1'b0;
    flush_next     = 1'b0;
    turn_next      = 1'b0;
    if (!listen_up) begin
      case (pos)
        lpcr_pkg::POS_START: begin
          pos_next = (data_byte == lpcr_pkg::CH_QUEST) ? lpcr_pkg::POS_ONE
                                                       : lpcr_pkg::POS_REJECT;
        end
        lpcr_pkg::POS_ONE: begin
          pos_next = (data_byte == lpcr_pkg::CH_R) ? lpcr_pkg::POS_TWO
                                                   : lpcr_pkg::POS_REJECT;
        end
        lpcr_pkg::POS_TWO: begin
          pos_next = (data_byte == lpcr_pkg::CH_L) ? lpcr_pkg::POS_THREE
                                                   : lpcr_pkg::POS_REJECT;
        end
        lpcr_pkg::POS_THREE: begin
          if (data_byte == lpcr_pkg::CH_SPACE) begin
            pos_next = lpcr_pkg::POS_CAPTURE;
          end else if (data_byte == lpcr_pkg::CH_R) begin
            pos_next = lpcr_pkg::POS_FOUR;
          end else begin
            pos_next = lpcr_pkg::POS_REJECT;
          end
        end
        lpcr_pkg::POS_FOUR: begin
          pos_next = (data_byte == lpcr_pkg::CH_SPACE) ? lpcr_pkg::POS_CAPTURE
                                                       : lpcr_pkg::POS_REJECT;
        end
        lpcr_pkg::POS_CAPTURE: begin
          cap_next   = 1'b1;
          flush_next = is_nl;
        end
        default: begin
          pos_next = pos;
        end
      endcase
      // Any newline ends the line and hands the link to the other side.
      if (is_nl) begin
        pos_next       = lpcr_pkg::POS_START;
        listen_up_next = 1'b1;
        turn_next      = 1'b1;
      end
    end else begin
      case (pos)
        lpcr_pkg::POS_START: begin
          pos_next = (data_byte == lpcr_pkg::CH_BANG) ? lpcr_pkg::POS_ONE
                                                      : lpcr_pkg::POS_REJECT;
        end
        lpcr_pkg::POS_ONE: begin
          pos_next = (data_byte == lpcr_pkg::CH_N || data_byte == lpcr_pkg::CH_P)
                     ? lpcr_pkg::POS_TWO : lpcr_pkg::POS_REJECT;
        end
        lpcr_pkg::POS_TWO: begin
          pos_next = (data_byte == lpcr_pkg::CH_SPACE) ? lpcr_pkg::POS_THREE
                                                       : lpcr_pkg::POS_REJECT;
        end
        lpcr_pkg::POS_THREE: begin
          if (is_nl) begin
            pos_next       = lpcr_pkg::POS_START;
            listen_up_next = 1'b0;
            turn_next      = 1'b1;
          end else begin
            pos_next = lpcr_pkg::POS_REJECT;
          end
        end
        default: begin
          // Rejected line: wait for its newline.
          pos_next = is_nl ? lpcr_pkg::POS_START : lpcr_pkg::POS_REJECT;
        end
      endcase
    end
  end

  // Control state: direction, match position and result valid.
  always_ff @(posedge clk) begin
    if (rst) begin
      listen_up    <= 1'b0;
      pos          <= lpcr_pkg::POS_START;
      result_valid <= 1'b0;
    end else begin
      if (accept) begin
        listen_up <= listen_up_next;
        pos       <= pos_next;
      end
      if (accept) begin
        result_valid <= 1'b1;
      end else if (result_ready) begin
        result_valid <= 1'b0;
      end
    end
  end

  // Result register payload.
  always_ff @(posedge clk) begin
    if (accept) begin
      out_byte    <= data_byte;
      to_upstream <= listen_up;
      capture     <= cap_next;
      flush       <= flush_next;
      turned      <= turn_next;
    end
  end

endmodule

// ----- rtl/lpcr_checker.sv -----
// Port-level checker for the line prefix capture relay, with its bind.
`include "line_prefix_capture_relay_core_defines.svh"

module lpcr_checker (
  input logic       clk,
  input logic       rst,
  input logic       data_valid,
  input logic       data_ready,
  input logic [7:0] data_byte,
  input logic       result_valid,
  input logic       result_ready,
  input logic [7:0] out_byte,
  input logic       to_upstream,
  input logic       capture,
  input logic       flush,
  input logic       turned
);

  // A stalled result holds its word.
  `LPCR_ASSERT_NEXT(a_hold, result_valid && !result_ready, result_valid && $stable(out_byte))

  // An accepted word shows up unchanged in the next result.
  `LPCR_ASSERT_NEXT(a_forward, data_valid && data_ready, result_valid && out_byte == $past(data_byte))

  // Capture and flush happen only on the downstream path, and flush only on a captured newline.
  `LPCR_ASSERT_NOW(a_cap_dir, result_valid && capture, !to_upstream)
  `LPCR_ASSERT_NOW(a_flush, result_valid && flush, capture && turned && out_byte == lpcr_pkg::CH_NL)

  // The relay turns only on a newline.
  `LPCR_ASSERT_NOW(a_turn_nl, result_valid && turned, out_byte == lpcr_pkg::CH_NL)

endmodule

bind line_prefix_capture_relay_core lpcr_checker u_lpcr_checker (.*);

// ----- bench/relay_result_checker.sv -----
// Checker that predicts and compares every result word of the line prefix capture relay.
`timescale 1ns / 1ps

module relay_result_checker (
  input  logic       clk,
  input  logic       rst,
  input  logic       data_valid,
  input  logic       data_ready,
  input  logic [7:0] data_byte,
  input  logic       result_valid,
  input  logic       result_ready,
  input  logic [7:0] out_byte,
  input  logic       to_upstream,
  input  logic       capture,
  input  logic       flush,
  input  logic       turned,
  output int         words_pending,
  output int         mismatch_count
);

  // One result word as the relay should present it.
  typedef struct packed {
    logic [7:0] out_byte;
    logic       to_upstream;
    logic       capture;
    logic       flush;
    logic       turned;
  } relay_word_t;

  relay_word_t     expected_words[$];
  logic            from_downstream;
  lpcr_pkg::pos_t  line_pos;
  int              word_index;

  initial begin
    words_pending  = 0;
    mismatch_count = 0;
  end

  // Print one line for a wrong or unexpected result word and count it.
  task automatic report_mismatch(input string what, input int got, input int want);
    $display("relay mismatch at result word %0d: %s got %0h, wanted %0h",
             word_index, what, got, want);
    mismatch_count++;
  endtask

  // Work out the result word for one input byte and advance the line matcher.
  function automatic relay_word_t predict_relay(input logic [7:0] c);
    relay_word_t    w;
    lpcr_pkg::pos_t p;
    w             = '0;
    w.out_byte    = c;
    w.to_upstream = from_downstream;
    p             = line_pos;
    if (!from_downstream) begin
      // Forwarding downstream: look for "?RL " or "?RLR ", then capture the line.
      case (p)
        lpcr_pkg::POS_START:
          p = (c == lpcr_pkg::CH_QUEST) ? lpcr_pkg::POS_ONE : lpcr_pkg::POS_REJECT;
        lpcr_pkg::POS_ONE:
          p = (c == lpcr_pkg::CH_R) ? lpcr_pkg::POS_TWO : lpcr_pkg::POS_REJECT;
        lpcr_pkg::POS_TWO:
          p = (c == lpcr_pkg::CH_L) ? lpcr_pkg::POS_THREE : lpcr_pkg::POS_REJECT;
        lpcr_pkg::POS_THREE: begin
          if (c == lpcr_pkg::CH_SPACE) p = lpcr_pkg::POS_CAPTURE;
          else if (c == lpcr_pkg::CH_R) p = lpcr_pkg::POS_FOUR;
          else p = lpcr_pkg::POS_REJECT;
        end
        lpcr_pkg::POS_FOUR:
          p = (c == lpcr_pkg::CH_SPACE) ? lpcr_pkg::POS_CAPTURE : lpcr_pkg::POS_REJECT;
        lpcr_pkg::POS_CAPTURE: begin
          w.capture = 1'b1;
          w.flush   = (c == lpcr_pkg::CH_NL);
        end
        default: ;
      endcase
      // Every newline in this direction turns the relay around.
      if (c == lpcr_pkg::CH_NL) begin
        p               = lpcr_pkg::POS_START;
        from_downstream = 1'b1;
        w.turned        = 1'b1;
      end
    end else begin
      // Forwarding upstream: only an exact "!N " or "!P " line turns it back.
      case (p)
        lpcr_pkg::POS_START:
          p = (c == lpcr_pkg::CH_BANG) ? lpcr_pkg::POS_ONE : lpcr_pkg::POS_REJECT;
        lpcr_pkg::POS_ONE:
          p = (c == lpcr_pkg::CH_N || c == lpcr_pkg::CH_P) ? lpcr_pkg::POS_TWO
                                                           : lpcr_pkg::POS_REJECT;
        lpcr_pkg::POS_TWO:
          p = (c == lpcr_pkg::CH_SPACE) ? lpcr_pkg::POS_THREE : lpcr_pkg::POS_REJECT;
        lpcr_pkg::POS_THREE: begin
          if (c == lpcr_pkg::CH_NL) begin
            p               = lpcr_pkg::POS_START;
            from_downstream = 1'b0;
            w.turned        = 1'b1;
          end else begin
            p = lpcr_pkg::POS_REJECT;
          end
        end
        default:
          p = (c == lpcr_pkg::CH_NL) ? lpcr_pkg::POS_START : lpcr_pkg::POS_REJECT;
      endcase
    end
    line_pos = p;
    return w;
  endfunction

  // Predict on accepted input words, compare on accepted result words.
  always @(posedge clk) begin
    relay_word_t want;
    if (rst) begin
      expected_words.delete();
      from_downstream = 1'b0;
      line_pos        = lpcr_pkg::POS_START;
      word_index      = 0;
    end else begin
      if (data_valid && data_ready) expected_words.push_back(predict_relay(data_byte));
      if (result_valid && result_ready) begin
        if (expected_words.size() == 0) begin
          report_mismatch("unexpected word, out_byte", out_byte, 0);
        end else begin
          want = expected_words.pop_front();
          if (out_byte !== want.out_byte)
            report_mismatch("out_byte", out_byte, want.out_byte);
          if (to_upstream !== want.to_upstream)
            report_mismatch("to_upstream", to_upstream, want.to_upstream);
          if (capture !== want.capture)
            report_mismatch("capture", capture, want.capture);
          if (flush !== want.flush)
            report_mismatch("flush", flush, want.flush);
          if (turned !== want.turned)
            report_mismatch("turned", turned, want.turned);
        end
        word_index++;
      end
    end
    words_pending <= expected_words.size();
  end

endmodule

// ----- bench/line_prefix_capture_relay_core_tb.sv -----
// Top of the relay testbench: clock, reset, byte stream stimulus and the verdict.
`timescale 1ns / 1ps

module line_prefix_capture_relay_core_tb;

  localparam int NUM_WORDS = 2000;

  logic       clk          = 1'b0;
  logic       rst          = 1'b1;
  logic       data_valid   = 1'b0;
  logic [7:0] data_byte    = 8'h00;
  logic       result_ready = 1'b0;
  logic       steady       = 1'b0;
  logic       data_ready;
  logic       result_valid;
  logic [7:0] out_byte;
  logic       to_upstream;
  logic       capture;
  logic       flush;
  logic       turned;
  int         words_pending;
  int         mismatch_count;
  int         sent_count   = 0;
  logic [7:0] line_bytes[$];

  always #5 clk = ~clk;

  line_prefix_capture_relay_core i_dut (
    .clk          (clk),
    .rst          (rst),
    .data_valid   (data_valid),
    .data_ready   (data_ready),
    .data_byte    (data_byte),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .out_byte     (out_byte),
    .to_upstream  (to_upstream),
    .capture      (capture),
    .flush        (flush),
    .turned       (turned)
  );

  relay_result_checker i_checker (
    .clk            (clk),
    .rst            (rst),
    .data_valid     (data_valid),
    .data_ready     (data_ready),
    .data_byte      (data_byte),
    .result_valid   (result_valid),
    .result_ready   (result_ready),
    .out_byte       (out_byte),
    .to_upstream    (to_upstream),
    .capture        (capture),
    .flush          (flush),
    .turned         (turned),
    .words_pending  (words_pending),
    .mismatch_count (mismatch_count)
  );

  // The result side stalls at random, except during the steady stretch.
  always @(posedge clk) begin
    if (rst) result_ready <= 1'b0;
    else result_ready <= steady || ($urandom_range(99) >= 26);
  end

  // Offer one word, after a random gap, and hold it until it is taken.
  task automatic send_word(input logic [7:0] b);
    while (!steady && $urandom_range(99) < 26) begin
      data_valid <= 1'b0;
      @(posedge clk);
    end
    data_byte  <= b;
    data_valid <= 1'b1;
    do @(posedge clk); while (!data_ready);
    sent_count++;
    steady <= (sent_count >= 700 && sent_count < 1000);
  endtask

  // Send the collected line and start a new one.
  task automatic send_line();
    foreach (line_bytes[i]) send_word(line_bytes[i]);
    line_bytes.delete();
  endtask

  // Collect a capture prefix, "?RL " or "?RLR ".
  task automatic add_capture_prefix();
    line_bytes.push_back(lpcr_pkg::CH_QUEST);
    line_bytes.push_back(lpcr_pkg::CH_R);
    line_bytes.push_back(lpcr_pkg::CH_L);
    if ($urandom_range(1)) line_bytes.push_back(lpcr_pkg::CH_R);
    line_bytes.push_back(lpcr_pkg::CH_SPACE);
  endtask

  // Collect a reply line body, "!N " or "!P ".
  task automatic add_reply_body();
    line_bytes.push_back(lpcr_pkg::CH_BANG);
    line_bytes.push_back($urandom_range(1) ? lpcr_pkg::CH_N : lpcr_pkg::CH_P);
    line_bytes.push_back(lpcr_pkg::CH_SPACE);
  endtask

  // Build one random line: mostly well formed, some broken or noise.
  task automatic build_random_line();
    int kind;
    int cut;
    kind = $urandom_range(99);
    if (kind < 40) begin
      add_capture_prefix();
      repeat ($urandom_range(6)) line_bytes.push_back(8'($urandom_range(255)));
    end else if (kind < 70) begin
      add_reply_body();
    end else if (kind < 82) begin
      // A prefix cut short before its end.
      if ($urandom_range(1)) add_capture_prefix();
      else add_reply_body();
      cut = int'($urandom_range(line_bytes.size() - 1));
      while (line_bytes.size() > cut) void'(line_bytes.pop_back());
      if ($urandom_range(1)) line_bytes.push_back(8'($urandom_range(255)));
    end else if (kind < 92) begin
      repeat ($urandom_range(5)) line_bytes.push_back(8'($urandom_range(255)));
    end
    line_bytes.push_back(lpcr_pkg::CH_NL);
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // Capture line with the long prefix and an all-ones byte; turns upstream.
    line_bytes = '{lpcr_pkg::CH_QUEST, lpcr_pkg::CH_R, lpcr_pkg::CH_L, lpcr_pkg::CH_R,
                   lpcr_pkg::CH_SPACE, 8'hFF, lpcr_pkg::CH_NL};
    send_line();
    // Empty line is rejected, so the exact reply after it is skipped.
    line_bytes = '{lpcr_pkg::CH_NL, lpcr_pkg::CH_BANG, lpcr_pkg::CH_P, lpcr_pkg::CH_SPACE,
                   lpcr_pkg::CH_NL};
    send_line();
    // Newline after "!N" rejects; the next (empty) line is skipped.
    line_bytes = '{lpcr_pkg::CH_BANG, lpcr_pkg::CH_N, lpcr_pkg::CH_NL, lpcr_pkg::CH_NL};
    send_line();
    // Newline after "!" rejects; skip one line, then turn back.
    line_bytes = '{lpcr_pkg::CH_BANG, lpcr_pkg::CH_NL, lpcr_pkg::CH_NL, lpcr_pkg::CH_BANG,
                   lpcr_pkg::CH_N, lpcr_pkg::CH_SPACE, lpcr_pkg::CH_NL};
    send_line();
    // Rejected downstream line with a zero byte still turns on its newline.
    line_bytes = '{8'h00, lpcr_pkg::CH_NL};
    send_line();

    while (sent_count < NUM_WORDS) begin
      build_random_line();
      send_line();
    end
    data_valid <= 1'b0;
    @(posedge clk);

    // Drain, then give the result register time to empty.
    while (words_pending != 0) @(posedge clk);
    repeat (5) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  // Hard stop if the handshakes never complete.
  initial begin
    #2_000_000;
    $display("tb: failure");
    $finish;
  end

endmodule
